FILE: rtl/binary_to_decimal_ascii_macros.svh
// assertion macros shared by the binary to decimal ascii rtl
// depends on a clk and rst in scope of the module that uses them
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, off during reset
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bdac_pkg.sv
// shared types and constants for the binary to decimal ascii converter
// no dependencies
package bdac_pkg;

  typedef logic [3:0] bcd_digit_t;

  // control that runs along the digit chain
  typedef struct packed {
    logic clear;   // zero every digit
    logic dabble;  // add-3 and shift in one binary bit
    logic shift;   // move every digit one place up
  } cell_ctrl_t;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_CR   = 8'd13;
  localparam logic [7:0] ASCII_LF   = 8'd10;

endpackage

FILE: rtl/bdac_cell.sv
// one bcd digit cell of the conversion chain
// depends on bdac_pkg
module bdac_cell
  import bdac_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  input  bcd_digit_t digit_in,
  output logic       bit_out,
  output bcd_digit_t digit
);

  bcd_digit_t adj;

  always_comb begin
    adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
    bit_out = adj[3];
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {adj[2:0], bit_in};
    end else if (ctrl.shift) begin
      digit <= digit_in;
    end
  end

endmodule

FILE: rtl/bdac_chain.sv
// row of bcd digit cells, least significant digit at index zero
// depends on bdac_pkg and bdac_cell
module bdac_chain
  import bdac_pkg::*;
#(
  parameter int NUM_DIGITS = 10
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  output bcd_digit_t top_digit
);

  logic       carry [NUM_DIGITS];
  bcd_digit_t dig   [NUM_DIGITS];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      bdac_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bit_in),
        .digit_in ('0),
        .bit_out  (carry[i]),
        .digit    (dig[i])
      );
    end else begin : g_rest
      bdac_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (carry[i-1]),
        .digit_in (dig[i-1]),
        .bit_out  (carry[i]),
        .digit    (dig[i])
      );
    end
  end

  assign top_digit = dig[NUM_DIGITS-1];

endmodule

FILE: rtl/binary_to_decimal_ascii.sv
// operation: a value is accepted, its bits shift msb first into the digit cell
//   chain, the NUM_DIGITS digit places are emitted without leading zeros, then CR and LF
// input: a new value is taken only in idle, once the LF of the last one has loaded;
//   the run is bit-serial through the digit cell chain; stalls on char_ready add to it
// reset: clears the sequencer and the output valid flag, digit cells are not reset
// depends on bdac_pkg, bdac_chain and binary_to_decimal_ascii_macros.svh
`include "binary_to_decimal_ascii_macros.svh"
module binary_to_decimal_ascii
  import bdac_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        value_valid,
  output logic        value_ready,
  input  logic [31:0] value,
  // output channel, one ascii byte per transfer
  output logic        char_valid,
  input  logic        char_ready,
  output logic [7:0]  char_byte,
  output logic        last
);

  // digits of 2**VALUE_WIDTH - 1, via 1233/4096 as log10(2)
  localparam int NUM_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_EMIT,
    S_CR,
    S_LF
  } state_t;

  state_t                   state;
  logic [VALUE_WIDTH-1:0]   sr;       // binary value, shifted out msb first
  logic [CNT_W-1:0]         cnt;      // shift cycles, then digits left
  logic                     started;  // first nonzero digit already sent

  // fit the fixed 32-bit input to the working width (mask or zero extend)
  logic [VALUE_WIDTH+31:0]  value_ext;
  logic [VALUE_WIDTH-1:0]   value_fit;

  cell_ctrl_t ctrl;
  bcd_digit_t top_digit;
  logic       in_xfer;
  logic       can_load;   // output register free for a new byte this cycle
  logic       skip;       // leading zero: shift it away without a transfer
  logic       load;       // a byte enters the output register this cycle

  assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
  assign value_fit = value_ext[VALUE_WIDTH-1:0];

  assign value_ready = (state == S_IDLE);
  assign in_xfer     = value_valid && value_ready;
  assign can_load    = !char_valid || char_ready;
  // the last digit place always prints, so zero gives a single '0'
  assign skip        = !started && (top_digit == 4'd0) && (cnt > CNT_W'(1));
  assign load        = can_load && (((state == S_EMIT) && !skip) ||
                                    (state == S_CR) || (state == S_LF));

  always_comb begin
    ctrl.clear  = in_xfer;
    ctrl.dabble = (state == S_CONV);
    ctrl.shift  = (state == S_EMIT) && (skip || can_load);
  end

  bdac_chain #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (sr[VALUE_WIDTH-1]),
    .top_digit (top_digit)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      started    <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      // drop the byte once it has been taken, unless a new one loads below
      if (char_valid && char_ready && !load) begin
        char_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            sr      <= value_fit;
            cnt     <= CNT_W'(VALUE_WIDTH);
            started <= 1'b0;
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          // one binary bit enters the chain per cycle
          sr <= {sr[VALUE_WIDTH-2:0], 1'b0};
          if (cnt == CNT_W'(1)) begin
            cnt   <= CNT_W'(NUM_DIGITS);
            state <= S_EMIT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (skip) begin
            cnt <= cnt - CNT_W'(1);
          end else if (can_load) begin
            char_valid <= 1'b1;
            char_byte  <= ASCII_ZERO + {4'b0000, top_digit};
            last       <= 1'b0;
            started    <= 1'b1;
            cnt        <= cnt - CNT_W'(1);
            if (cnt == CNT_W'(1)) begin
              state <= S_CR;
            end
          end
        end
        S_CR: begin
          if (can_load) begin
            char_valid <= 1'b1;
            char_byte  <= ASCII_CR;
            last       <= 1'b0;
            state      <= S_LF;
          end
        end
        S_LF: begin
          if (can_load) begin
            char_valid <= 1'b1;
            char_byte  <= ASCII_LF;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a transfer in starts a full-length shift run
  `BDA_ASSERT_NEXT(a_conv_start, in_xfer, (state == S_CONV) && (cnt == CNT_W'(VALUE_WIDTH)), "conversion did not start with a full shift count")
  // only the line feed carries last
  `BDA_ASSERT_NOW(a_last_is_lf, char_valid && last, char_byte == ASCII_LF, "last set on a byte other than line feed")
  // a stalled byte is never overwritten by the sequencer
  `BDA_ASSERT_NEXT(a_out_hold, char_valid && !char_ready, char_valid && $stable(char_byte) && $stable(last), "output byte changed while stalled")
  // digit emission never runs past the last digit place
  `BDA_ASSERT_NOW(a_emit_cnt, state == S_EMIT, cnt != '0, "digit counter empty during emission")

endmodule

FILE: test/tb_binary_to_decimal_ascii.sv
// testbench for binary_to_decimal_ascii: drives 32-bit values and checks the
// decimal ascii bytes, cr, lf and last marker against an in-bench predictor
// depends on bdac_pkg and the binary_to_decimal_ascii rtl
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii
  import bdac_pkg::*;
();

  // expected byte stream for every accepted value, oldest first
  class char_scoreboard_t;
    typedef struct {
      logic [7:0] code;
      logic       end_mark;
    } ascii_char_t;

    ascii_char_t pending_chars[$];
    int          errors = 0;

    // one line per mismatch
    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // decimal digits most significant first, no leading zeros, then cr and lf
    task note_value(logic [31:0] number);
      logic [31:0] rest;
      logic [7:0]  digits[$];
      ascii_char_t entry;
      rest = number;
      do begin
        digits.push_front(ASCII_ZERO + 8'(rest % 32'd10));
        rest = rest / 32'd10;
      end while (rest != 0);
      foreach (digits[i]) begin
        entry.code     = digits[i];
        entry.end_mark = 1'b0;
        pending_chars.push_back(entry);
      end
      entry.code     = ASCII_CR;
      entry.end_mark = 1'b0;
      pending_chars.push_back(entry);
      entry.code     = ASCII_LF;
      entry.end_mark = 1'b1;
      pending_chars.push_back(entry);
    endtask

    task check_char(logic [7:0] code, logic end_mark);
      ascii_char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected byte %0d last %0b", code, end_mark));
      end else begin
        want = pending_chars.pop_front();
        if (code !== want.code) begin
          report($sformatf("char_byte %0d, expected %0d", code, want.code));
        end
        if (end_mark !== want.end_mark) begin
          report($sformatf("last %0b, expected %0b", end_mark, want.end_mark));
        end
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        value_valid;
  logic        value_ready;
  logic [31:0] value;
  logic        char_valid;
  logic        char_ready;
  logic [7:0]  char_byte;
  logic        last;

  char_scoreboard_t sb;

  binary_to_decimal_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_ready(value_ready),
    .value      (value),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_byte  (char_byte),
    .last       (last)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // sample both channels at the edge; values read here are the pre-edge ones
  always @(posedge clk) begin
    if (!rst) begin
      if (value_valid && value_ready) begin
        sb.note_value(value);
      end
      if (char_valid && char_ready) begin
        sb.check_char(char_byte, last);
      end
    end
  end

  // offer one value and hold it until the transfer happens
  task send_value(logic [31:0] number);
    value_valid <= 1'b1;
    value       <= number;
    do @(posedge clk); while (!value_ready);
  endtask

  // drop valid for a random number of cycles so gaps land on every phase
  task sender_gap();
    int cycles;
    cycles = $urandom_range(1, 60);
    value_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  function automatic longint unsigned power_of_ten(int exponent);
    longint unsigned acc;
    acc = 1;
    for (int i = 0; i < exponent; i++) begin
      acc = acc * 10;
    end
    return acc;
  endfunction

  // random value with an evenly chosen digit count, so short numbers are common
  function automatic logic [31:0] value_with_digits();
    int          ndigits;
    logic [31:0] lo;
    logic [31:0] hi;
    ndigits = $urandom_range(1, 10);
    lo = (ndigits == 1) ? 32'd0 : 32'(power_of_ten(ndigits - 1));
    hi = (ndigits == 10) ? 32'hFFFF_FFFF : 32'(power_of_ten(ndigits) - 1);
    return $urandom_range(hi, lo);
  endfunction

  // values sitting on a digit-count boundary: 10^k - 1, 10^k, 10^k + 1
  function automatic logic [31:0] boundary_value();
    int          exponent;
    logic [31:0] base;
    exponent = $urandom_range(1, 9);
    base = 32'(power_of_ten(exponent));
    return base + 32'($urandom_range(2, 0)) - 32'd1;
  endfunction

  // receiver: random stalls, one long hold-off that backs the block up into
  // its input, and a long stretch where it always takes bytes
  initial begin
    int cycle;
    char_ready <= 1'b0;
    @(negedge rst);
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle >= 1500 && cycle < 2100) begin
        char_ready <= 1'b0;
      end else if (cycle >= 4000 && cycle < 7000) begin
        char_ready <= 1'b1;
      end else begin
        char_ready <= ($urandom_range(0, 99) >= 13);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] corner_values[$];
    logic [31:0] number;
    int          pick;
    corner_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd12345,
                      32'd999_999_999, 32'd1_000_000_000, 32'd1_000_000_001,
                      32'd2_147_483_647, 32'h8000_0000, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                      32'd4_000_000_000, 32'd1_234_567_890, 32'd0, 32'd7};
    sb = new();
    rst         <= 1'b1;
    value_valid <= 1'b0;
    value       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: zero, single digit, the length edges 9/10, 99/100 and 999999999/1000000000, all ones
    foreach (corner_values[i]) begin
      send_value(corner_values[i]);
      if ($urandom_range(0, 99) < 13) begin
        sender_gap();
      end
    end

    // random part; items 120 to 200 go back to back with no gaps
    for (int n = 0; n < 310; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        number = $urandom();
      end else if (pick < 90) begin
        number = value_with_digits();
      end else begin
        number = boundary_value();
      end
      send_value(number);
      if ((n < 120 || n > 200) && $urandom_range(0, 99) < 13) begin
        sender_gap();
      end
    end
    value_valid <= 1'b0;
    // let the edge pass that puts the last accepted value into the scoreboard
    @(posedge clk);

    // let the last bytes drain, then watch a while for anything extra
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
